### rtl/core/mfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types and codes for the median filtered follow controller.
// ----------------------------------------------------------------------------
package mfc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_TARGET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_MARGIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_MARGIN = 3'd4;

  // motion commands
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FWD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BACK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd3;

  // phase codes as reported on the result word
  localparam int PHASE_CODE_W = 2;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_CALIB  = 2'd0;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_WAIT   = 2'd1;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_FOLLOW = 2'd2;

  // calibration counter width
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    PH_CALIB  = 3'b001,
    PH_WAIT   = 3'b010,
    PH_FOLLOW = 3'b100
  } phase_t;

endpackage
`default_nettype wire

### rtl/core/mfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_front
// Accepts raw samples and forms the median of the last three raw samples.
// ----------------------------------------------------------------------------
module mfc_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   s_valid,
  output logic                        s_ready,
  input  wire logic [SAMPLE_BITS-1:0] s_sample,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic [SAMPLE_BITS-1:0]      q_filtered
);
  import mfc_pkg::*;

  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic [SAMPLE_BITS-1:0] lo, hi, mid;

  assign s_ready = !q_full;
  assign q_push  = s_valid && s_ready;

  // median of three: min/max of the first pair, then clamp
  always_comb begin
    lo         = (s_sample < prev_r) ? s_sample : prev_r;
    hi         = (s_sample < prev_r) ? prev_r : s_sample;
    mid        = (hi < older_r) ? hi : older_r;
    q_filtered = (lo > mid) ? lo : mid;
  end

  always_comb begin
    prev_nxt  = prev_r;
    older_nxt = older_r;
    if (q_push) begin
      older_nxt = prev_r;
      prev_nxt  = s_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      older_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      older_r <= older_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_queue
// Two-entry queue of filtered values between the front and back parts.
// ----------------------------------------------------------------------------
module mfc_queue #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] push_data,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        not_empty,
  output logic [SAMPLE_BITS-1:0]      pop_data
);
  import mfc_pkg::*;

  localparam int DEPTH = 2;

  logic [SAMPLE_BITS-1:0] mem_r [DEPTH];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r, count_nxt;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

### rtl/core/mfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfc_back
// Phase controller: calibrate, wait for the band, follow with a dead zone.
// ----------------------------------------------------------------------------
module mfc_back #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mfc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [SAMPLE_BITS-1:0]        cfg_wdata,
  input  wire logic                          q_not_empty,
  input  wire logic [SAMPLE_BITS-1:0]        q_filtered,
  output logic                               q_pop,
  output logic                               m_valid,
  input  wire logic                          m_ready,
  output logic [SAMPLE_BITS-1:0]             m_filtered,
  output logic [mfc_pkg::CMD_W-1:0]          m_command,
  output logic [mfc_pkg::PHASE_CODE_W-1:0]   m_phase
);
  import mfc_pkg::*;

  logic [SAMPLE_BITS-1:0] far_r, close_r, target_r, back_r, fwd_r;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic               out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]  out_filt_r;
  logic [CMD_W-1:0]        out_cmd_r, cmd;
  logic [PHASE_CODE_W-1:0] out_phase_r, phase_code;
  logic                    in_band;
  logic [SAMPLE_BITS:0]    upper;
  logic [SAMPLE_BITS-1:0]  lower;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r    <= SAMPLE_BITS'(32'd1000);
      close_r  <= SAMPLE_BITS'(32'd3000);
      target_r <= SAMPLE_BITS'(32'd1500);
      back_r   <= SAMPLE_BITS'(32'd100);
      fwd_r    <= SAMPLE_BITS'(32'd50);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FAR_LIMIT:      far_r    <= cfg_wdata;
        CFG_CLOSE_LIMIT:    close_r  <= cfg_wdata;
        CFG_FOLLOW_TARGET:  target_r <= cfg_wdata;
        CFG_BACK_MARGIN:    back_r   <= cfg_wdata;
        CFG_FORWARD_MARGIN: fwd_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_pop = q_not_empty && (!out_valid_r || m_ready);

  always_comb begin
    in_band   = (q_filtered > far_r) && (q_filtered < close_r);
    upper     = {1'b0, target_r} + {1'b0, back_r};
    lower     = (fwd_r > target_r) ? '0 : (target_r - fwd_r);
    cnt_inc   = cnt_r + CNT_W'(1);
    cmd       = CMD_NONE;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (q_filtered >= far_r && q_filtered <= close_r) begin
          if (in_band) begin
            phase_nxt = PH_FOLLOW;
          end else begin
            phase_nxt = PH_CALIB;
            cnt_nxt   = '0;
          end
        end
      end
      PH_FOLLOW: begin
        if ({1'b0, q_filtered} > upper) begin
          cmd = CMD_BACK;
        end else if (q_filtered < lower) begin
          cmd = CMD_FWD;
        end else begin
          cmd = CMD_STOP;
        end
        if (!in_band) begin
          phase_nxt = PH_CALIB;
          cnt_nxt   = '0;
        end
      end
      PH_CALIB: begin
        if (cnt_inc >= CNT_W'(CALIB_SAMPLES) || cnt_inc == '0) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        phase_nxt = PH_CALIB;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    unique case (phase_nxt)
      PH_WAIT:   phase_code = PHASE_CODE_WAIT;
      PH_FOLLOW: phase_code = PHASE_CODE_FOLLOW;
      default:   phase_code = PHASE_CODE_CALIB;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (m_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CALIB;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_filt_r  <= q_filtered;
      out_cmd_r   <= cmd;
      out_phase_r <= phase_code;
    end
  end

  assign m_valid    = out_valid_r;
  assign m_filtered = out_filt_r;
  assign m_command  = out_cmd_r;
  assign m_phase    = out_phase_r;

  // only the follow phase issues motion commands
  a_cmd_only_follow : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && phase_r != PH_FOLLOW) |=> (m_command == CMD_NONE))
    else $error("command issued outside follow phase");

  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(CALIB_SAMPLES))
    else $error("calibration count out of range");

endmodule
`default_nettype wire

### rtl/core/median_filtered_follow_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filtered_follow_controller
// Median-of-three distance filter followed by a calibrate/wait/follow
// controller with a hysteresis band around the follow target.
// ----------------------------------------------------------------------------
//  port group  dir  word contents (low bit first)
//  in_*        in   sample
//  out_*       out  filtered, command, phase_now
//  cfg_*       in   register index, write data (no read-back)
//
//  one word per cycle sustained while out_tready is high; a word shows on
//  out_ in the cycle after the one in which the controller takes it from
//  the queue. the front forms the median in the accept cycle; a two-entry
//  queue feeds the controller, whose phase updates on each word it takes.
//  rst_n is synchronous: history clears to zero, phase to calibrate.
//  out_tready low holds the output register; the queue then fills and
//  in_tready drops.
// ----------------------------------------------------------------------------
module median_filtered_follow_controller #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SAMPLE_BITS   = 12,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + mfc_pkg::CMD_W + mfc_pkg::PHASE_CODE_W + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [IN_W-1:0]               in_tdata,   // sample
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [OUT_W-1:0]                   out_tdata,  // filtered, command, phase_now
  input  wire logic                          cfg_we,
  input  wire logic [mfc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [SAMPLE_BITS-1:0]        cfg_wdata
);
  import mfc_pkg::*;

  logic                    q_push, q_full, q_pop, q_not_empty;
  logic [SAMPLE_BITS-1:0]  q_in, q_out;
  logic [SAMPLE_BITS-1:0]  o_filtered;
  logic [CMD_W-1:0]        o_command;
  logic [PHASE_CODE_W-1:0] o_phase;

  mfc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .s_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_filtered (q_in)
  );

  mfc_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  mfc_back #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_filtered  (q_out),
    .q_pop       (q_pop),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .m_filtered  (o_filtered),
    .m_command   (o_command),
    .m_phase     (o_phase)
  );

  assign out_tdata = OUT_W'({o_phase, o_command, o_filtered});

endmodule
`default_nettype wire
